// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the form percent decoder.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/fpd_pkg.sv
// Package of the form percent decoder: character codes, status and phase
// codes, item and result structs, and the hex digit decode function.
package fpd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;

  localparam logic [15:0] CAP_RESET = 16'd64;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_ESCAPE = 2'd1,
    ST_TOO_LONG   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       done_res;
    logic [1:0] status;
  } result_t;

  // Per-string decoder state, exported for checking.
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  high_nibble;
    logic [15:0] written_count;
    status_t     error_code;
  } dec_state_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] diff;
    begin
      diff = 8'd0;
      if (b >= CH_0 && b <= CH_9) begin
        diff = b - CH_0;
        hex_digit = {1'b1, diff[3:0]};
      end else if (b >= CH_LA && b <= CH_LF) begin
        diff = b - CH_LA + 8'd10;
        hex_digit = {1'b1, diff[3:0]};
      end else if (b >= CH_UA && b <= CH_UF) begin
        diff = b - CH_UA + 8'd10;
        hex_digit = {1'b1, diff[3:0]};
      end else begin
        hex_digit = 5'd0;
      end
    end
  endfunction

endpackage

// File: hw/rtl/fpd_core.sv
// Decode core of the form percent decoder: per-string state registers and
// the single-pass decode of one item. Depends on fpd_pkg.
module fpd_core import fpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  item_t       item,
  input  logic [15:0] out_capacity,
  output result_t     result,
  output dec_state_t  state
);

  dec_state_t state_next;
  logic       emit;
  logic [7:0] ch;
  logic [4:0] dig;
  logic [16:0] count_inc;

  // Decode one item against the current string state.
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    ch         = 8'd0;
    dig        = hex_digit(item.in_byte);
    count_inc  = {1'b0, state.written_count} + 17'd1;

    if (item.has_byte && state.error_code == ST_OK) begin
      unique case (state.phase)
        PH_PLAIN: begin
          if (item.in_byte == CH_PERCENT) begin
            state_next.phase = PH_HIGH;
          end else begin
            ch   = (item.in_byte == CH_PLUS) ? CH_SPACE : item.in_byte;
            emit = 1'b1;
          end
        end
        PH_HIGH: begin
          if (!dig[4]) begin
            state_next.error_code = ST_BAD_ESCAPE;
          end else begin
            state_next.high_nibble = dig[3:0];
            state_next.phase       = PH_LOW;
          end
        end
        default: begin
          state_next.phase = PH_PLAIN;
          if (!dig[4]) begin
            state_next.error_code = ST_BAD_ESCAPE;
          end else begin
            ch = {state.high_nibble, dig[3:0]};
            if (ch == 8'd0) begin
              state_next.error_code = ST_BAD_ESCAPE;
            end else begin
              emit = 1'b1;
            end
          end
        end
      endcase

      // Capacity check; one byte is kept back for the terminator.
      if (emit) begin
        if (count_inc >= {1'b0, out_capacity}) begin
          state_next.error_code = ST_TOO_LONG;
          emit = 1'b0;
        end else begin
          state_next.written_count = count_inc[15:0];
        end
      end
    end

    // An escape left open at the end of the string is a bad escape.
    if (item.last && state_next.error_code == ST_OK && state_next.phase != PH_PLAIN) begin
      state_next.error_code = ST_BAD_ESCAPE;
    end

    result.out_byte  = emit ? ch : 8'd0;
    result.out_valid = emit;
    result.done_res  = item.last;
    result.status    = item.last ? state_next.error_code : ST_OK;

    if (item.last) begin
      state_next.phase         = PH_PLAIN;
      state_next.high_nibble   = 4'd0;
      state_next.written_count = 16'd0;
      state_next.error_code    = ST_OK;
    end
  end

  // State register, advanced once per decoded item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= PH_PLAIN;
      state.high_nibble   <= 4'd0;
      state.written_count <= 16'd0;
      state.error_code    <= ST_OK;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/form_percent_decoder.sv
// Top level of the form percent decoder: input register, decode core,
// result register and configuration register. Depends on fpd_pkg,
// fpd_core and assert_macros.svh.
//
// Channel   | Direction | Transaction carries
// s_axis    | in        | tdata = in_byte, tuser = has_byte, tlast = last
// m_axis    | out       | tdata = out_byte, tuser = {status, out_valid}, tlast = done_res
// cfg       | in        | data = out_capacity
//
// One item per cycle is sustained while m_axis is not stalled; each item is
// held in the input register, is decoded into the result register, and is
// then offered on m_axis. A stalled m_axis holds the result and the input
// register fills, after which s_axis_tready drops. Synchronous reset clears
// the string state, empties both registers and sets out_capacity to 64.
`include "assert_macros.svh"

module form_percent_decoder import fpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [0] out_valid, [2:1] status
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        in_full;
  item_t       in_item;
  logic        out_full;
  result_t     out_res;
  result_t     core_res;
  dec_state_t  core_state;
  logic        step;
  logic [15:0] out_capacity;

  // Decode advances when the input register holds an item and the result
  // register is free or being drained.
  assign step          = in_full && (!out_full || m_axis_tready);
  assign s_axis_tready = !in_full || step;
  assign cfg_ready     = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      out_capacity <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.in_byte  <= s_axis_tdata;
      in_item.has_byte <= s_axis_tuser;
      in_item.last     <= s_axis_tlast;
    end
  end

  fpd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .item         (in_item),
    .out_capacity (out_capacity),
    .result       (core_res),
    .state        (core_state)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (step) begin
      out_full <= 1'b1;
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = out_res.out_byte;
  assign m_axis_tuser  = {out_res.status, out_res.out_valid};
  assign m_axis_tlast  = out_res.done_res;

  // A status other than ok appears only on the final result of a string.
  `ASSERT_IMPL(a_status_on_last, clk, rst,
    m_axis_tvalid && !m_axis_tlast, m_axis_tuser[2:1] == ST_OK)
  // A decoded byte is never delivered together with an error status.
  `ASSERT_IMPL(a_no_byte_on_error, clk, rst,
    m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[2:1] == ST_OK)
  // Decoding the final item returns the string state to its reset values.
  `ASSERT_NEXT(a_clear_after_last, clk, rst,
    step && in_item.last,
    core_state.phase == PH_PLAIN && core_state.written_count == 16'd0 &&
    core_state.error_code == ST_OK)

endmodule
